[hw/rtl/tsqs_pkg.sv]
`default_nettype none
package tsqs_pkg;

  // Field widths
  localparam int unsigned CoordW   = 16;
  localparam int unsigned StatusW  = 9;
  localparam int unsigned PressW   = 8;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned InDataW  = 48;
  localparam int unsigned OutDataW = 40;

  // Serial step counter covers one pass of CoordW bits
  localparam int unsigned CntW = $clog2(CoordW);

  // Register indexes
  localparam logic [CfgIdxW-1:0] RegXLow   = 3'd0;
  localparam logic [CfgIdxW-1:0] RegXHigh  = 3'd1;
  localparam logic [CfgIdxW-1:0] RegYLow   = 3'd2;
  localparam logic [CfgIdxW-1:0] RegYHigh  = 3'd3;
  localparam logic [CfgIdxW-1:0] RegXSpan  = 3'd4;
  localparam logic [CfgIdxW-1:0] RegYSpan  = 3'd5;
  localparam logic [CfgIdxW-1:0] RegPenup  = 3'd6;

  // Register reset values
  localparam logic [CoordW-1:0] XLowRst  = 16'd0;
  localparam logic [CoordW-1:0] XHighRst = 16'd4095;
  localparam logic [CoordW-1:0] YLowRst  = 16'd0;
  localparam logic [CoordW-1:0] YHighRst = 16'd4095;
  localparam logic [CoordW-1:0] XSpanRst = 16'd320;
  localparam logic [CoordW-1:0] YSpanRst = 16'd480;
  localparam logic [CoordW-1:0] PenupRst = 16'd20;

  // Status word decoding
  localparam logic [2:0] OpsExpected = 3'd2;
  localparam logic [PressW-1:0] FullPressure = 8'd255;

endpackage
`default_nettype wire

[hw/rtl/touch_sample_qualify_scale.sv]
`default_nettype none
// Channel   Dir  Handshake                   Payload
// s_axis    in   s_axis_tvalid/s_axis_tready tdata: raw_x, raw_y, status_word, data_ready
//                                            tuser: cmd (0 sample, 1 tick)
// m_axis    out  m_axis_tvalid/m_axis_tready tdata: pos_x, pos_y, pressure; tuser: touching
// cfg       in   cfg_valid_i/cfg_ready_o     cfg_index_i, cfg_data_i (always ready)
//
// An accepted sample runs both axes in parallel lanes: first a bit-serial shift-add
// multiply, then a restoring division, then the final state that loads the output.
// A tick is handled in the idle state, or goes to the final state when it produces the pen-up report.
// One item is processed at a time; the result waits in the output register while
// the next item is accepted. A stalled output holds the block in its final state.
// Reset restores the register defaults and disarms the pen-up countdown.
module touch_sample_qualify_scale (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              s_axis_tvalid,
  output logic                             s_axis_tready,
  // [15:0] raw_x, [31:16] raw_y, [40:32] status_word, [41] data_ready, [47:42] zero
  input  wire  [tsqs_pkg::InDataW-1:0]     s_axis_tdata,
  // [0] cmd
  input  wire                              s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  wire                              m_axis_tready,
  // [15:0] pos_x, [31:16] pos_y, [39:32] pressure
  output logic [tsqs_pkg::OutDataW-1:0]    m_axis_tdata,
  // [0] touching
  output logic                             m_axis_tuser,
  input  wire                              cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire  [tsqs_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  wire  [tsqs_pkg::CoordW-1:0]      cfg_data_i
);
  import tsqs_pkg::*;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StMul  = 2'd1;
  localparam logic [1:0] StDiv  = 2'd2;
  localparam logic [1:0] StFin  = 2'd3;
  localparam int unsigned ProdW = 2 * CoordW;
  localparam logic [CntW-1:0] CntLast = CntW'(CoordW - 1);

  // Configuration registers
  logic [CoordW-1:0] x_low_q, x_high_q, y_low_q, y_high_q;
  logic [CoordW-1:0] x_span_q, y_span_q, penup_ticks_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_low_q       <= XLowRst;
      x_high_q      <= XHighRst;
      y_low_q       <= YLowRst;
      y_high_q      <= YHighRst;
      x_span_q      <= XSpanRst;
      y_span_q      <= YSpanRst;
      penup_ticks_q <= PenupRst;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        RegXLow:  x_low_q       <= cfg_data_i;
        RegXHigh: x_high_q      <= cfg_data_i;
        RegYLow:  y_low_q       <= cfg_data_i;
        RegYHigh: y_high_q      <= cfg_data_i;
        RegXSpan: x_span_q      <= cfg_data_i;
        RegYSpan: y_span_q      <= cfg_data_i;
        RegPenup: penup_ticks_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Input field decode
  logic [CoordW-1:0]  raw_x, raw_y;
  logic [StatusW-1:0] status_word;
  logic               data_ready, cmd;
  logic               in_acc, sample_ok;

  assign raw_x       = s_axis_tdata[CoordW-1:0];
  assign raw_y       = s_axis_tdata[2*CoordW-1:CoordW];
  assign status_word = s_axis_tdata[2*CoordW+StatusW-1:2*CoordW];
  assign data_ready  = s_axis_tdata[2*CoordW+StatusW];
  assign cmd         = s_axis_tuser;
  assign in_acc      = s_axis_tvalid && s_axis_tready;
  assign sample_ok   = !cmd && data_ready && (status_word[8:6] == OpsExpected)
                       && (status_word[5:1] == 5'd0);

  // Per-lane operands: lane 0 is x, lane 1 is inverted y
  logic [CoordW-1:0] diff_w [2];
  logic [CoordW-1:0] span_w [2];
  logic              spok_w [2];
  logic [CoordW-1:0] res_w  [2];

  always_comb begin
    diff_w[0] = (raw_x >= x_low_q) ? raw_x - x_low_q : '0;
    diff_w[1] = (y_high_q >= raw_y) ? y_high_q - raw_y : '0;
    span_w[0] = x_high_q - x_low_q;
    span_w[1] = y_high_q - y_low_q;
    spok_w[0] = x_high_q > x_low_q;
    spok_w[1] = y_high_q > y_low_q;
    res_w[0]  = x_span_q;
    res_w[1]  = y_span_q;
  end

  // Control
  logic [1:0]        state_q, state_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              penup_res_q, penup_res_d;
  logic [CoordW-1:0] penup_count_q, penup_count_d;
  logic              penup_armed_q, penup_armed_d;
  logic              out_valid_q, out_load;

  assign s_axis_tready = (state_q == StIdle);
  assign out_load      = (state_q == StFin) && (!out_valid_q || m_axis_tready);

  always_comb begin
    state_d       = state_q;
    cnt_d         = cnt_q;
    penup_res_d   = penup_res_q;
    penup_count_d = penup_count_q;
    penup_armed_d = penup_armed_q;
    case (state_q)
      StIdle: begin
        cnt_d = '0;
        if (in_acc && !cmd && sample_ok) begin
          penup_count_d = penup_ticks_q;
          penup_armed_d = 1'b1;
          penup_res_d   = 1'b0;
          state_d       = StMul;
        end else if (in_acc && cmd && penup_armed_q) begin
          if (penup_count_q > 16'd1) begin
            penup_count_d = penup_count_q - 16'd1;
          end else begin
            penup_count_d = '0;
            penup_armed_d = 1'b0;
            penup_res_d   = 1'b1;
            state_d       = StFin;
          end
        end
      end
      StMul: begin
        cnt_d = cnt_q + CntW'(1);
        if (cnt_q == CntLast) state_d = StDiv;
      end
      StDiv: begin
        cnt_d = cnt_q + CntW'(1);
        if (cnt_q == CntLast) state_d = StFin;
      end
      StFin: begin
        if (out_load) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= StIdle;
      cnt_q         <= '0;
      penup_res_q   <= 1'b0;
      penup_count_q <= '0;
      penup_armed_q <= 1'b0;
    end else begin
      state_q       <= state_d;
      cnt_q         <= cnt_d;
      penup_res_q   <= penup_res_d;
      penup_count_q <= penup_count_d;
      penup_armed_q <= penup_armed_d;
    end
  end

  // Serial lanes: shift-add multiply, then restoring divide in the same register
  logic [ProdW-1:0]  prod_q [2];
  logic [CoordW-1:0] diff_q [2];
  logic [CoordW-1:0] span_q [2];
  logic              spok_q [2];
  logic [CoordW:0]   msum   [2];
  logic [CoordW:0]   dtrial [2];
  logic              dge    [2];
  logic [CoordW:0]   drem   [2];
  logic [CoordW-1:0] lane_out [2];

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      msum[l]   = {1'b0, prod_q[l][ProdW-1:CoordW]}
                  + (prod_q[l][0] ? {1'b0, diff_q[l]} : '0);
      dtrial[l] = {prod_q[l][ProdW-1:CoordW], prod_q[l][CoordW-1]};
      dge[l]    = dtrial[l] >= {1'b0, span_q[l]};
      drem[l]   = dge[l] ? dtrial[l] - {1'b0, span_q[l]} : dtrial[l];
      // A span that is not positive (high not above low) gives 0; a difference at or beyond the span saturates
      if (!spok_q[l]) lane_out[l] = '0;
      else if (diff_q[l] >= span_q[l]) lane_out[l] = res_w[l];
      else lane_out[l] = prod_q[l][CoordW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int l = 0; l < 2; l++) begin
      if (state_q == StIdle && in_acc) begin
        prod_q[l] <= {{CoordW{1'b0}}, res_w[l]};
        diff_q[l] <= diff_w[l];
        span_q[l] <= span_w[l];
        spok_q[l] <= spok_w[l];
      end else if (state_q == StMul) begin
        prod_q[l] <= {msum[l], prod_q[l][CoordW-1:1]};
      end else if (state_q == StDiv && spok_q[l]) begin
        prod_q[l] <= {drem[l][CoordW-1:0], prod_q[l][CoordW-2:0], dge[l]};
      end
    end
  end

  // Output register
  logic [CoordW-1:0] pos_x_q, pos_y_q;
  logic              touch_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      pos_x_q <= penup_res_q ? '0 : lane_out[0];
      pos_y_q <= penup_res_q ? '0 : lane_out[1];
      touch_q <= !penup_res_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = touch_q;
  assign m_axis_tdata  = {(touch_q ? FullPressure : {PressW{1'b0}}), pos_y_q, pos_x_q};

  // Checks
  a_penup_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == '0))
    else $error("pen-up report with nonzero fields");

  a_load_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load |=> out_valid_q) and ($rose(out_valid_q) |-> $past(state_q) == StFin))
    else $error("output register loaded outside final state");

  a_armed_in_calc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StMul || state_q == StDiv) |-> penup_armed_q)
    else $error("scaling a sample without arming the pen-up countdown");

  a_x_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata[CoordW-1:0] <= x_span_q))
    else $error("x position beyond resolution");

endmodule
`default_nettype wire
